// ===== src/tobc_pkg.sv =====
// ============================================================================
// tobc_pkg: shared types and constants of the text-or-binary classifier
// Request payloads, per-buffer scan state, verdict reasons and signature bytes.
// ============================================================================
`default_nettype none

package tobc_pkg;

  // Scan window and derived widths
  localparam int unsigned SCAN_LIMIT  = 512;
  localparam int unsigned CNT_W       = $clog2(SCAN_LIMIT + 1);
  localparam int unsigned PROD_W      = CNT_W + 7;   // count * 100 fits here
  localparam int unsigned EARLY_INDEX = 32;          // first index of the early ratio test
  localparam int unsigned RATIO_NUM   = 100;
  localparam int unsigned RATIO_DEN   = 11;

  // Byte classes
  localparam logic [7:0] CTRL_LO   = 8'd7;
  localparam logic [7:0] CTRL_HI   = 8'd14;
  localparam logic [7:0] PRINT_LO  = 8'd32;
  localparam logic [7:0] PRINT_HI  = 8'd127;
  localparam logic [7:0] CONT_LO   = 8'd128;
  localparam logic [7:0] CONT_HI   = 8'd191;
  localparam logic [7:0] LEAD2_LO  = 8'd194;
  localparam logic [7:0] LEAD2_HI  = 8'd223;
  localparam logic [7:0] LEAD3_LO  = 8'd224;
  localparam logic [7:0] LEAD3_HI  = 8'd239;

  // Signature lengths
  localparam int unsigned MARK_LEN = 3;
  localparam int unsigned PDF_LEN  = 5;

  // Verdict values
  localparam logic VERDICT_TEXT   = 1'b0;
  localparam logic VERDICT_BINARY = 1'b1;

  // Reason codes
  typedef enum logic [2:0] {
    REASON_EMPTY       = 3'd0,
    REASON_MARK        = 3'd1,
    REASON_PDF         = 3'd2,
    REASON_ZERO        = 3'd3,
    REASON_EARLY_RATIO = 3'd4,
    REASON_FINAL_RATIO = 3'd5,
    REASON_TEXT        = 3'd6
  } reason_e;

  // Pending UTF-8 sequence
  typedef enum logic [1:0] {
    SEQ_NONE         = 2'd0,
    SEQ_TWO_TAIL     = 2'd1,
    SEQ_THREE_FIRST  = 2'd2,
    SEQ_THREE_SECOND = 2'd3
  } seq_e;

  // Input request
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [31:0] buffer_length;
  } in_item_t;

  // Result
  typedef struct packed {
    logic       verdict;
    logic [2:0] reason;
  } out_item_t;

  // Per-buffer scan state
  typedef struct packed {
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] scan;
    logic [CNT_W-1:0] susp;
    logic             len_ge3;
    logic             len_ge5;
    logic             mark;
    logic             pdf;
    seq_e             seq;
    logic             done;
  } scan_state_t;

  // Byte order mark bytes
  function automatic logic [7:0] mark_byte(input logic [1:0] idx);
    logic [7:0] v;
    unique case (idx)
      2'd0:    v = 8'hEF;
      2'd1:    v = 8'hBB;
      2'd2:    v = 8'hBF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // "%PDF-" bytes
  function automatic logic [7:0] pdf_byte(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0:    v = 8'h25;
      3'd1:    v = 8'h50;
      3'd2:    v = 8'h44;
      3'd3:    v = 8'h46;
      3'd4:    v = 8'h2D;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // suspicious*100 >= 11*scan_length
  function automatic logic ratio_hit(input logic [CNT_W-1:0] cnt,
                                     input logic [CNT_W-1:0] scan);
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
    lhs = PROD_W'(cnt) * PROD_W'(RATIO_NUM);
    rhs = PROD_W'(scan) * PROD_W'(RATIO_DEN);
    return lhs >= rhs;
  endfunction

endpackage

`default_nettype wire

// ===== src/text_or_binary_classifier.sv =====
// ============================================================================
// text_or_binary_classifier: per-buffer text or binary verdict
// Streams buffer bytes, scans the leading window and gives one verdict each.
// ============================================================================
//
//  channel | direction | payload               | handshake
//  --------+-----------+-----------------------+---------------------------
//  in      | request   | tobc_pkg::in_item_t   | in_valid_i / in_stall_o
//  out     | result    | tobc_pkg::out_item_t  | out_valid_o / out_stall_i
//
//  One byte per cycle unless a held result stalls the input; the byte that
//  decides a verdict passes the input register, then the result register.
//  The step logic sits between those two registers and updates the scan state.
//  After reset the block is idle: bytes are dropped until a first_byte request.
//  A held result stalls the input only once the input register is also full.
//
`default_nettype none

module text_or_binary_classifier (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tobc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tobc_pkg::out_item_t out_data_o
);

  logic                  in_valid_q;
  tobc_pkg::in_item_t    in_q;
  tobc_pkg::scan_state_t state_q;
  tobc_pkg::scan_state_t state_d;
  logic                  res_valid;
  tobc_pkg::out_item_t   res;
  logic                  out_valid_q;
  tobc_pkg::out_item_t   out_q;
  logic                  advance;
  logic                  process;
  logic                  in_take;

  // Handshake control
  assign advance    = !out_valid_q || !out_stall_i;
  assign process    = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Classification step
  tobc_eval u_eval (
    .state_i     (state_q),
    .item_i      (in_q),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{pos: '0, scan: '0, susp: '0, len_ge3: 1'b0, len_ge5: 1'b0,
                       mark: 1'b0, pdf: 1'b0, seq: tobc_pkg::SEQ_NONE, done: 1'b1};
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (process) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= process && res_valid;
      end
      if (process) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (process && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== src/tobc_eval.sv =====
// ============================================================================
// tobc_eval: one-byte classification step
// Combinational next state and optional verdict for one request.
// ============================================================================
`default_nettype none

module tobc_eval (
  input  tobc_pkg::scan_state_t state_i,
  input  tobc_pkg::in_item_t    item_i,
  output tobc_pkg::scan_state_t state_o,
  output logic                  res_valid_o,
  output tobc_pkg::out_item_t   res_o
);

  localparam int unsigned CW = tobc_pkg::CNT_W;

  tobc_pkg::scan_state_t n;
  logic          fin;
  logic          examine;
  logic [7:0]    b;
  logic [CW-1:0] pos;
  logic [CW:0]   pos_p1;
  logic [CW:0]   pos_p2;
  logic [CW-1:0] clamp_len;
  logic          is_cont;
  logic          is_susp;
  logic          is_lead2;
  logic          is_lead3;

  // Byte classes and clamped length
  always_comb begin
    b         = item_i.data_byte;
    is_cont   = (b >= tobc_pkg::CONT_LO) && (b <= tobc_pkg::CONT_HI);
    is_susp   = !((b >= tobc_pkg::CTRL_LO) && (b <= tobc_pkg::CTRL_HI)) &&
                !((b >= tobc_pkg::PRINT_LO) && (b <= tobc_pkg::PRINT_HI));
    is_lead2  = (b >= tobc_pkg::LEAD2_LO) && (b <= tobc_pkg::LEAD2_HI);
    is_lead3  = (b >= tobc_pkg::LEAD3_LO) && (b <= tobc_pkg::LEAD3_HI);
    clamp_len = (item_i.buffer_length > 32'(tobc_pkg::SCAN_LIMIT)) ?
                CW'(tobc_pkg::SCAN_LIMIT) : item_i.buffer_length[CW-1:0];
  end

  // Step; fin marks that the outcome of this byte is settled
  always_comb begin
    n           = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    fin         = 1'b0;
    examine     = 1'b1;
    pos         = state_i.pos;
    pos_p1      = {1'b0, state_i.pos} + (CW+1)'(1);
    pos_p2      = {1'b0, state_i.pos} + (CW+1)'(2);

    // New buffer
    if (item_i.first_byte) begin
      n.pos     = '0;
      n.susp    = '0;
      n.seq     = tobc_pkg::SEQ_NONE;
      n.mark    = 1'b0;
      n.pdf     = 1'b0;
      n.scan    = clamp_len;
      n.len_ge3 = item_i.buffer_length >= 32'(tobc_pkg::MARK_LEN);
      n.len_ge5 = item_i.buffer_length >= 32'(tobc_pkg::PDF_LEN);
      n.done    = 1'b0;
      if (item_i.buffer_length == 32'd0) begin
        res_valid_o   = 1'b1;
        res_o.verdict = tobc_pkg::VERDICT_TEXT;
        res_o.reason  = tobc_pkg::REASON_EMPTY;
        n.done        = 1'b1;
        fin           = 1'b1;
      end
    end

    // Idle or already decided
    if (!fin && n.done) begin
      fin = 1'b1;
    end
    if (!fin && (n.pos >= n.scan)) begin
      n.done = 1'b1;
      fin    = 1'b1;
    end

    // Signature prefixes
    if (!fin) begin
      pos    = n.pos;
      pos_p1 = {1'b0, pos} + (CW+1)'(1);
      pos_p2 = {1'b0, pos} + (CW+1)'(2);
      n.pos  = pos_p1[CW-1:0];
      if (pos == '0) begin
        n.mark = (b == tobc_pkg::mark_byte(2'd0));
        n.pdf  = (b == tobc_pkg::pdf_byte(3'd0));
      end else if (pos < CW'(tobc_pkg::PDF_LEN)) begin
        n.mark = n.mark && (pos < CW'(tobc_pkg::MARK_LEN)) &&
                 (b == tobc_pkg::mark_byte(pos[1:0]));
        n.pdf  = n.pdf && (b == tobc_pkg::pdf_byte(pos[2:0]));
      end
      if ((pos == CW'(tobc_pkg::MARK_LEN - 1)) && n.mark && n.len_ge3) begin
        res_valid_o   = 1'b1;
        res_o.verdict = tobc_pkg::VERDICT_TEXT;
        res_o.reason  = tobc_pkg::REASON_MARK;
        n.done        = 1'b1;
        fin           = 1'b1;
      end else if ((pos == CW'(tobc_pkg::PDF_LEN - 1)) && n.pdf && n.len_ge5) begin
        res_valid_o   = 1'b1;
        res_o.verdict = tobc_pkg::VERDICT_BINARY;
        res_o.reason  = tobc_pkg::REASON_PDF;
        n.done        = 1'b1;
        fin           = 1'b1;
      end
    end

    // Pending UTF-8 sequence
    if (!fin) begin
      unique case (n.seq)
        tobc_pkg::SEQ_TWO_TAIL: begin
          n.seq   = tobc_pkg::SEQ_NONE;
          examine = 1'b0;
          if (!is_cont) begin
            n.susp = n.susp + CW'(1);
            if ((pos >= CW'(tobc_pkg::EARLY_INDEX)) &&
                tobc_pkg::ratio_hit(n.susp, n.scan)) begin
              res_valid_o   = 1'b1;
              res_o.verdict = tobc_pkg::VERDICT_BINARY;
              res_o.reason  = tobc_pkg::REASON_EARLY_RATIO;
              n.done        = 1'b1;
              fin           = 1'b1;
            end
          end
        end
        tobc_pkg::SEQ_THREE_FIRST: begin
          examine = 1'b0;
          if (is_cont) begin
            n.seq = tobc_pkg::SEQ_THREE_SECOND;
          end else begin
            n.seq  = tobc_pkg::SEQ_NONE;
            n.susp = n.susp + CW'(1);
            if ((pos >= CW'(tobc_pkg::EARLY_INDEX)) &&
                tobc_pkg::ratio_hit(n.susp, n.scan)) begin
              res_valid_o   = 1'b1;
              res_o.verdict = tobc_pkg::VERDICT_BINARY;
              res_o.reason  = tobc_pkg::REASON_EARLY_RATIO;
              n.done        = 1'b1;
              fin           = 1'b1;
            end
          end
        end
        tobc_pkg::SEQ_THREE_SECOND: begin
          n.seq = tobc_pkg::SEQ_NONE;
          if (is_cont) begin
            examine = 1'b0;
          end else begin
            // counted at the index before this byte, then the byte is examined
            n.susp = n.susp + CW'(1);
            if ((pos >= CW'(tobc_pkg::EARLY_INDEX + 1)) &&
                tobc_pkg::ratio_hit(n.susp, n.scan)) begin
              res_valid_o   = 1'b1;
              res_o.verdict = tobc_pkg::VERDICT_BINARY;
              res_o.reason  = tobc_pkg::REASON_EARLY_RATIO;
              n.done        = 1'b1;
              fin           = 1'b1;
            end
          end
        end
        tobc_pkg::SEQ_NONE: begin
          n.seq = tobc_pkg::SEQ_NONE;
        end
      endcase
    end

    // Plain byte checks
    if (!fin && examine) begin
      if (b == 8'd0) begin
        res_valid_o   = 1'b1;
        res_o.verdict = tobc_pkg::VERDICT_BINARY;
        res_o.reason  = tobc_pkg::REASON_ZERO;
        n.done        = 1'b1;
        fin           = 1'b1;
      end else if (is_susp) begin
        if (is_lead2 && (pos_p1 < {1'b0, n.scan})) begin
          n.seq = tobc_pkg::SEQ_TWO_TAIL;
        end else if (is_lead3 && (pos_p2 < {1'b0, n.scan})) begin
          n.seq = tobc_pkg::SEQ_THREE_FIRST;
        end else begin
          n.susp = n.susp + CW'(1);
          if ((pos >= CW'(tobc_pkg::EARLY_INDEX)) &&
              tobc_pkg::ratio_hit(n.susp, n.scan)) begin
            res_valid_o   = 1'b1;
            res_o.verdict = tobc_pkg::VERDICT_BINARY;
            res_o.reason  = tobc_pkg::REASON_EARLY_RATIO;
            n.done        = 1'b1;
            fin           = 1'b1;
          end
        end
      end
    end

    // End of scan window
    if (!fin && (pos_p1 >= {1'b0, n.scan})) begin
      res_valid_o = 1'b1;
      n.done      = 1'b1;
      if (tobc_pkg::ratio_hit(n.susp, n.scan)) begin
        res_o.verdict = tobc_pkg::VERDICT_BINARY;
        res_o.reason  = tobc_pkg::REASON_FINAL_RATIO;
      end else begin
        res_o.verdict = tobc_pkg::VERDICT_TEXT;
        res_o.reason  = tobc_pkg::REASON_TEXT;
      end
    end

    state_o = n;
  end

endmodule

`default_nettype wire

// ===== src/tobc_checker.sv =====
// ============================================================================
// tobc_checker: port-level checks of the classifier
// Watches the top-level ports and flags broken results and handshakes.
// ============================================================================
`default_nettype none

module tobc_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  tobc_pkg::in_item_t  in_data_i,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  tobc_pkg::out_item_t out_data_o
);

  // Held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Input only backs up behind a held result
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // Verdict agrees with its reason code
  a_reason_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.reason != 3'd7) &&
      (out_data_o.verdict == ((out_data_o.reason == tobc_pkg::REASON_PDF) ||
                              (out_data_o.reason == tobc_pkg::REASON_ZERO) ||
                              (out_data_o.reason == tobc_pkg::REASON_EARLY_RATIO) ||
                              (out_data_o.reason == tobc_pkg::REASON_FINAL_RATIO))))
    else $error("verdict does not match reason");

  // Empty buffer is reported as text right away
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.first_byte &&
     (in_data_i.buffer_length == 32'd0))
    ##1 (!out_valid_o || !out_stall_i)
    |=> out_valid_o && (out_data_o.verdict == tobc_pkg::VERDICT_TEXT) &&
        (out_data_o.reason == tobc_pkg::REASON_EMPTY))
    else $error("empty buffer verdict missing");

  // Zero first byte of a non-empty buffer is binary right away
  a_zero_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.first_byte &&
     (in_data_i.buffer_length != 32'd0) && (in_data_i.data_byte == 8'd0))
    ##1 (!out_valid_o || !out_stall_i)
    |=> out_valid_o && (out_data_o.verdict == tobc_pkg::VERDICT_BINARY) &&
        (out_data_o.reason == tobc_pkg::REASON_ZERO))
    else $error("zero byte verdict missing");

endmodule

bind text_or_binary_classifier tobc_checker u_tobc_checker (.*);

`default_nettype wire

// ===== sim/tobc_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// tobc_tb_pkg: verdict scoreboard for the text-or-binary classifier bench
// Keeps a cycle-free copy of the per-buffer scan, queues the verdict each
// accepted request should cause, and compares results in order.
// ----------------------------------------------------------------------------
package tobc_tb_pkg;

  import tobc_pkg::*;

  localparam int unsigned WINDOW_MAX = 512;   // bytes scanned per buffer
  localparam int unsigned IDX_W      = 10;    // wide enough for WINDOW_MAX
  localparam int unsigned EARLY_FROM = 32;    // first index of the early ratio test

  localparam logic [7:0] BOM_SIG [0:2] = '{8'hEF, 8'hBB, 8'hBF};
  localparam logic [7:0] PDF_SIG [0:4] = '{8'h25, 8'h50, 8'h44, 8'h46, 8'h2D};

  class verdict_scoreboard;

    // scan state of the buffer in flight
    logic [IDX_W-1:0] byte_idx;
    logic [IDX_W-1:0] window_len;
    logic [IDX_W-1:0] odd_count;
    logic             len_ge3;
    logic             len_ge5;
    logic             bom_match;
    logic             pdf_match;
    seq_e             utf8_wait;
    logic             decided;

    out_item_t pending_verdicts[$];
    int unsigned errors;
    int unsigned verdicts_checked;
    int unsigned expected_total;
    int unsigned reason_hits[8];

    function new();
      byte_idx   = '0;
      window_len = '0;
      odd_count  = '0;
      len_ge3    = 1'b0;
      len_ge5    = 1'b0;
      bom_match  = 1'b0;
      pdf_match  = 1'b0;
      utf8_wait  = SEQ_NONE;
      decided    = 1'b1;
      errors     = 0;
      verdicts_checked = 0;
      expected_total   = 0;
      foreach (reason_hits[i]) reason_hits[i] = 0;
    endfunction

    task report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      errors++;
    endtask

    function bit over_ratio();
      return 32'(odd_count) * 100 >= 32'(window_len) * 11;
    endfunction

    function bit early_hit(input logic [IDX_W-1:0] idx);
      return 32'(idx) >= EARLY_FROM && over_ratio();
    endfunction

    function bit is_tail(input logic [7:0] b);
      return b >= 8'd128 && b <= 8'd191;
    endfunction

    function out_item_t decide(input logic verdict, input reason_e why);
      out_item_t r;
      r.verdict = verdict;
      r.reason  = why;
      decided   = 1'b1;
      return r;
    endfunction

    // One scan step. Returns 0 when the request is dropped (idle or decided).
    function bit classify_byte(input in_item_t it, output bit got, output out_item_t v);
      logic [7:0]       b;
      logic [IDX_W-1:0] p;
      bit               examine;
      b       = it.data_byte;
      got     = 1'b0;
      v       = '0;
      examine = 1'b1;

      // a new buffer restarts everything, even mid-buffer
      if (it.first_byte) begin
        byte_idx   = '0;
        odd_count  = '0;
        utf8_wait  = SEQ_NONE;
        bom_match  = 1'b0;
        pdf_match  = 1'b0;
        window_len = (it.buffer_length > WINDOW_MAX) ? IDX_W'(WINDOW_MAX)
                                                     : IDX_W'(it.buffer_length);
        len_ge3    = it.buffer_length >= 3;
        len_ge5    = it.buffer_length >= 5;
        decided    = 1'b0;
        if (it.buffer_length == 0) begin
          got = 1'b1;
          v   = decide(VERDICT_TEXT, REASON_EMPTY);
          return 1'b1;
        end
      end
      if (decided) return 1'b0;
      p = byte_idx;
      if (p >= window_len) begin
        decided = 1'b1;
        return 1'b0;
      end
      byte_idx = p + 1'b1;

      // signature prefixes
      if (p == 0) begin
        bom_match = (b == BOM_SIG[0]);
        pdf_match = (b == PDF_SIG[0]);
      end else if (p < 5) begin
        bom_match = bom_match && p < 3 && b == BOM_SIG[p];
        pdf_match = pdf_match && b == PDF_SIG[p];
      end
      if (p == 2 && bom_match && len_ge3) begin
        got = 1'b1;
        v   = decide(VERDICT_TEXT, REASON_MARK);
        return 1'b1;
      end
      if (p == 4 && pdf_match && len_ge5) begin
        got = 1'b1;
        v   = decide(VERDICT_BINARY, REASON_PDF);
        return 1'b1;
      end

      // trailing bytes of a pending UTF-8 sequence
      case (utf8_wait)
        SEQ_TWO_TAIL: begin
          utf8_wait = SEQ_NONE;
          examine   = 1'b0;
          if (!is_tail(b)) begin
            odd_count++;
            if (early_hit(p)) begin
              got = 1'b1;
              v   = decide(VERDICT_BINARY, REASON_EARLY_RATIO);
              return 1'b1;
            end
          end
        end
        SEQ_THREE_FIRST: begin
          examine = 1'b0;
          if (is_tail(b)) begin
            utf8_wait = SEQ_THREE_SECOND;
          end else begin
            utf8_wait = SEQ_NONE;
            odd_count++;
            if (early_hit(p)) begin
              got = 1'b1;
              v   = decide(VERDICT_BINARY, REASON_EARLY_RATIO);
              return 1'b1;
            end
          end
        end
        SEQ_THREE_SECOND: begin
          utf8_wait = SEQ_NONE;
          if (is_tail(b)) begin
            examine = 1'b0;
          end else begin
            // counted against the previous index, byte itself still examined
            odd_count++;
            if (early_hit(p - 1'b1)) begin
              got = 1'b1;
              v   = decide(VERDICT_BINARY, REASON_EARLY_RATIO);
              return 1'b1;
            end
          end
        end
        default: utf8_wait = SEQ_NONE;
      endcase

      // plain byte checks
      if (examine) begin
        if (b == 8'd0) begin
          got = 1'b1;
          v   = decide(VERDICT_BINARY, REASON_ZERO);
          return 1'b1;
        end
        if (!(b >= 8'd7 && b <= 8'd14) && !(b >= 8'd32 && b <= 8'd127)) begin
          if (b >= 8'd194 && b <= 8'd223 && 32'(p) + 1 < 32'(window_len)) begin
            utf8_wait = SEQ_TWO_TAIL;
          end else if (b >= 8'd224 && b <= 8'd239 && 32'(p) + 2 < 32'(window_len)) begin
            utf8_wait = SEQ_THREE_FIRST;
          end else begin
            odd_count++;
            if (early_hit(p)) begin
              got = 1'b1;
              v   = decide(VERDICT_BINARY, REASON_EARLY_RATIO);
              return 1'b1;
            end
          end
        end
      end

      // last byte of the window
      if (32'(p) + 1 >= 32'(window_len)) begin
        got = 1'b1;
        v   = over_ratio() ? decide(VERDICT_BINARY, REASON_FINAL_RATIO)
                           : decide(VERDICT_TEXT, REASON_TEXT);
      end
      return 1'b1;
    endfunction

    // accepted request: advance the scan copy, queue any verdict
    function bit note_request(input in_item_t it);
      bit        got;
      out_item_t v;
      bit        took;
      took = classify_byte(it, got, v);
      if (got) begin
        pending_verdicts.push_back(v);
        expected_total++;
      end
      return took;
    endfunction

    // accepted result: compare with the oldest queued verdict
    task check_result(input out_item_t got);
      out_item_t want;
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict %0b reason %0d with none pending",
                                  got.verdict, got.reason));
      end else begin
        want = pending_verdicts.pop_front();
        verdicts_checked++;
        reason_hits[want.reason]++;
        if (got.verdict !== want.verdict)
          report_mismatch($sformatf("verdict %0b, want %0b", got.verdict, want.verdict));
        if (got.reason !== want.reason)
          report_mismatch($sformatf("reason %0d, want %0d", got.reason, want.reason));
      end
    endtask

    task drain_check();
      if (pending_verdicts.size() != 0)
        report_mismatch($sformatf("%0d verdicts never came", pending_verdicts.size()));
    endtask

  endclass

endpackage

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: bench for the text-or-binary classifier
// Directed buffers hit every verdict reason but the early ratio, and the UTF-8
// corner cases, then random buffers of mixed content run under random idle and
// stall bursts; every verdict is checked against the scoreboard's own scan.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import tobc_pkg::*;
  import tobc_tb_pkg::*;

  localparam int unsigned ITEM_GOAL    = 1550;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  typedef enum int {FILL_TEXT, FILL_UTF8, FILL_RAW, FILL_BOM, FILL_PDF} fill_e;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_req    = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_res;

  verdict_scoreboard sb;
  logic [7:0]  body[$];
  bit          calm_in;
  logic        wind_down = 1'b0;
  int unsigned sent;
  int unsigned consumed;
  int unsigned buffers_started;
  int unsigned cycle_cnt;
  int unsigned stall_left;
  int unsigned mood_left;
  bit          out_quiet;

  text_or_binary_classifier dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stall bursts, with quiet stretches
  always @(posedge clk) begin
    if (mood_left == 0) begin
      out_quiet = ($urandom_range(0, 3) == 0);
      mood_left = $urandom_range(20, 200);
    end else begin
      mood_left--;
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!out_quiet && !wind_down && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_res);
  end

  // one request, with an optional idle burst ahead of it
  task automatic send_request(input logic [7:0] data, input logic first,
                              input logic [31:0] len);
    in_item_t it;
    it.data_byte     = data;
    it.first_byte    = first;
    it.buffer_length = len;
    if (!calm_in && !wind_down && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (sb.note_request(it)) consumed++;
  endtask

  // send the first cnt bytes of body; later items carry junk lengths
  task automatic drive_buffer(input logic [31:0] len, input int unsigned cnt);
    buffers_started++;
    for (int unsigned i = 0; i < cnt; i++)
      send_request(body[i], i == 0, (i == 0) ? len : $urandom());
  endtask

  function automatic logic [7:0] plain_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(7, 14));
    return 8'($urandom_range(32, 127));
  endfunction

  function automatic logic [7:0] odd_byte();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(1, 6));
      1:       return 8'($urandom_range(15, 31));
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  function automatic logic [7:0] text_byte(input int unsigned pct);
    if ($urandom_range(0, 599) == 0) return 8'h00;
    if ($urandom_range(0, 99) < pct) return odd_byte();
    return plain_byte();
  endfunction

  task automatic build_body(input int unsigned n, input fill_e style,
                            input int unsigned pct);
    body.delete();
    // signature styles: full prefix, sometimes with one byte spoiled
    if (style == FILL_BOM) body = '{BOM_SIG[0], BOM_SIG[1], BOM_SIG[2]};
    if (style == FILL_PDF) body = '{PDF_SIG[0], PDF_SIG[1], PDF_SIG[2], PDF_SIG[3], PDF_SIG[4]};
    if (body.size() != 0 && $urandom_range(0, 2) == 0)
      body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(0, 255));
    while (body.size() < n) begin
      case (style)
        FILL_RAW: body.push_back(8'($urandom_range(0, 255)));
        FILL_UTF8: begin
          case ($urandom_range(0, 9))
            0, 1: begin
              body.push_back(8'($urandom_range(194, 223)));
              body.push_back(8'($urandom_range(128, 191)));
            end
            2, 3: begin
              body.push_back(8'($urandom_range(224, 239)));
              body.push_back(8'($urandom_range(128, 191)));
              body.push_back(8'($urandom_range(128, 191)));
            end
            4: begin
              // lead followed by anything: often a broken sequence
              body.push_back(8'($urandom_range(192, 239)));
              body.push_back(8'($urandom_range(0, 255)));
            end
            default: body.push_back(text_byte(pct));
          endcase
        end
        default: body.push_back(text_byte(pct));
      endcase
    end
  endtask

  initial begin
    logic [31:0] len;
    fill_e       style;
    int unsigned pct;
    int unsigned n;
    int unsigned cut;
    int unsigned r;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle request, empty buffer, mark, pdf, zero
    calm_in = 1'b1;
    send_request(8'hFF, 1'b0, 32'hFFFF_FFFF);
    body = '{8'h00};
    drive_buffer(32'd0, 1);
    body = '{BOM_SIG[0], BOM_SIG[1], BOM_SIG[2]};
    drive_buffer(32'd3, 3);
    // mark cut short by the length: judged by the ratio instead
    body = '{BOM_SIG[0], BOM_SIG[1]};
    drive_buffer(32'd2, 2);
    body = '{PDF_SIG[0], PDF_SIG[1], PDF_SIG[2], PDF_SIG[3], PDF_SIG[4]};
    drive_buffer(32'hFFFF_FFFF, 5);
    // zero byte decides, the next byte is dropped
    body = '{8'h00, 8'h41};
    drive_buffer(32'd2, 2);
    // bad two-byte tail, bad second tail of three, lead too close to the end
    body = '{8'hC3, 8'h41, 8'hE2, 8'h80, 8'h41, 8'hE2};
    drive_buffer(32'd6, 6);
    // restart in the middle of a buffer
    body = '{8'h41};
    drive_buffer(32'd4, 1);
    drive_buffer(32'd1, 1);

    // random buffers
    while (sent < ITEM_GOAL) begin
      if (!wind_down && sent > ITEM_GOAL * 85 / 100) wind_down <= 1'b1;
      calm_in = ($urandom_range(0, 3) == 0);
      // stray requests between buffers
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3))
          send_request(8'($urandom_range(0, 255)), 1'b0, $urandom());
      r = $urandom_range(0, 99);
      if (r < 6)       len = 32'd0;
      else if (r < 80) len = $urandom_range(1, 16);
      else if (r < 95) len = $urandom_range(17, 64);
      else if (r < 99) len = $urandom_range(65, 520);
      else             len = $urandom();
      r = $urandom_range(0, 9);
      case (r)
        0, 1, 2, 3: style = FILL_TEXT;
        4, 5:       style = FILL_UTF8;
        6:          style = FILL_RAW;
        7:          style = FILL_BOM;
        8:          style = FILL_PDF;
        default:    style = FILL_TEXT;
      endcase
      pct = (r == 9) ? $urandom_range(10, 40) : $urandom_range(0, 20);
      n = ((len > WINDOW_MAX) ? WINDOW_MAX : len) + $urandom_range(0, 2);
      if (n == 0) n = 1;
      build_body(n, style, pct);
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, body.size()) : body.size();
      drive_buffer(len, cut);
    end
    in_valid <= 1'b0;

    // drain
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.drain_check();

    $display("covered %0d buffers, %0d requests sent, %0d scanned, %0d verdicts checked",
             buffers_started, sent, consumed, sb.verdicts_checked);
    $display("by reason: empty %0d mark %0d pdf %0d zero %0d early %0d final %0d text %0d",
             sb.reason_hits[REASON_EMPTY], sb.reason_hits[REASON_MARK],
             sb.reason_hits[REASON_PDF], sb.reason_hits[REASON_ZERO],
             sb.reason_hits[REASON_EARLY_RATIO], sb.reason_hits[REASON_FINAL_RATIO],
             sb.reason_hits[REASON_TEXT]);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
